[src/aeha_pkg.sv]
// Shared types, status codes and duration match function for the AEHA IR frame decoder.
package aeha_pkg;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_DONE     = 3'd1,
        ST_SKIP     = 3'd2,
        ST_ERROR    = 3'd3,
        ST_NOT_AEHA = 3'd4
    } frame_status_t;

    localparam logic [11:0] TIME_UNIT_RESET = 12'd440;
    localparam logic [9:0]  TOLERANCE_RESET = 10'd150;

    typedef enum logic {
        REG_TIME_UNIT = 1'b0,
        REG_TOLERANCE = 1'b1
    } reg_index_t;

    // True when dur lies in [nom - tol, nom + tol].
    function automatic logic near_nom(logic [14:0] dur, logic [15:0] nom, logic [9:0] tol);
        logic [16:0] lhs;
        logic [16:0] rhs;
        lhs = {2'b00, dur} + {7'b0, tol};
        rhs = {1'b0, nom} + {7'b0, tol};
        return (lhs >= {1'b0, nom}) && ({2'b00, dur} <= rhs);
    endfunction

endpackage

[src/aeha_ir_frame_decoder.sv]
// AEHA IR frame decoder: one pulse symbol in, one decoded bit and frame status out.
// Path: an accepted input word passes through the input register and then the result register.
// Throughput: one word per cycle; the input register drains into the result register
// whenever the result register is empty or being taken, so both sides run back to back.
// Reset (aresetn low, synchronous): both registers empty, frame state at leader,
// time_unit = 440, tolerance = 150.
module aeha_ir_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [14:0] high_duration, [29:15] low_duration
    input  logic        s_tlast,   // frame_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] bit_value, [3:1] frame_status
    output logic        m_tuser,   // [0] bit_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [11:0] time_unit_reg;
    logic [9:0]  tolerance_reg;

    logic        in_valid_reg;
    logic [14:0] high_reg;
    logic [14:0] low_reg;
    logic        last_reg;

    logic        out_valid_reg;
    logic        bit_valid_reg;
    logic        bit_value_reg;
    aeha_pkg::frame_status_t status_reg;

    logic        expect_leader_reg, expect_leader_next;
    logic        leader_good_reg, leader_good_next;
    logic [1:0]  count_mod4_reg, count_mod4_next;
    logic        count_nz_reg, count_nz_next;
    logic [1:0]  total_sat_reg, total_sat_next;
    logic        illegal_reg, illegal_next;

    logic        bit_valid_next;
    logic        bit_value_next;
    aeha_pkg::frame_status_t status_next;

    logic        advance;
    logic        cfg_write;
    logic [15:0] nom1, nom3, nom4, nom8;
    logic        hi_ok1, lo_ok1, lo_ok3, lead_ok, dropped, sym_illegal;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (aeha_pkg::reg_index_t'(paddr[2]))
            aeha_pkg::REG_TIME_UNIT: prdata = {20'b0, time_unit_reg};
            aeha_pkg::REG_TOLERANCE: prdata = {22'b0, tolerance_reg};
            default:                 prdata = 32'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_unit_reg <= aeha_pkg::TIME_UNIT_RESET;
            tolerance_reg <= aeha_pkg::TOLERANCE_RESET;
        end else if (cfg_write) begin
            unique case (aeha_pkg::reg_index_t'(paddr[2]))
                aeha_pkg::REG_TIME_UNIT: time_unit_reg <= pwdata[11:0];
                aeha_pkg::REG_TOLERANCE: tolerance_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            high_reg <= s_tdata[14:0];
            low_reg  <= s_tdata[29:15];
            last_reg <= s_tlast;
        end
    end

    assign nom1 = {4'b0, time_unit_reg};
    assign nom3 = {3'b0, time_unit_reg, 1'b0} + {4'b0, time_unit_reg};
    assign nom4 = {2'b0, time_unit_reg, 2'b0};
    assign nom8 = {1'b0, time_unit_reg, 3'b0};

    assign hi_ok1  = aeha_pkg::near_nom(high_reg, nom1, tolerance_reg);
    assign lo_ok1  = aeha_pkg::near_nom(low_reg, nom1, tolerance_reg);
    assign lo_ok3  = aeha_pkg::near_nom(low_reg, nom3, tolerance_reg);
    assign lead_ok = aeha_pkg::near_nom(high_reg, nom8, tolerance_reg)
                  && aeha_pkg::near_nom(low_reg, nom4, tolerance_reg);
    assign sym_illegal = !hi_ok1 || (!lo_ok1 && !lo_ok3);
    assign dropped     = last_reg && (low_reg == 15'd0);

    always_comb begin
        expect_leader_next = expect_leader_reg;
        leader_good_next   = leader_good_reg;
        count_mod4_next    = count_mod4_reg;
        count_nz_next      = count_nz_reg;
        illegal_next       = illegal_reg;
        total_sat_next     = (total_sat_reg == 2'd3) ? 2'd3 : total_sat_reg + 2'd1;
        bit_valid_next     = 1'b0;
        bit_value_next     = 1'b0;
        status_next        = aeha_pkg::ST_BUSY;

        if (expect_leader_reg) begin
            expect_leader_next = 1'b0;
            leader_good_next   = lead_ok;
            if (last_reg) begin
                status_next = (!lead_ok && total_sat_next == 2'd3)
                            ? aeha_pkg::ST_NOT_AEHA : aeha_pkg::ST_SKIP;
            end
        end else if (!leader_good_reg) begin
            if (last_reg) begin
                status_next = (total_sat_next == 2'd3)
                            ? aeha_pkg::ST_NOT_AEHA : aeha_pkg::ST_SKIP;
            end
        end else begin
            if (!dropped) begin
                count_mod4_next = count_mod4_reg + 2'd1;
                count_nz_next   = 1'b1;
                if (sym_illegal) begin
                    illegal_next = 1'b1;
                end else if (!illegal_reg) begin
                    bit_valid_next = 1'b1;
                    bit_value_next = !lo_ok1;
                end
            end
            if (last_reg) begin
                if (!count_nz_next || count_mod4_next != 2'd0) begin
                    status_next = aeha_pkg::ST_SKIP;
                end else if (illegal_next) begin
                    status_next = aeha_pkg::ST_ERROR;
                end else begin
                    status_next = aeha_pkg::ST_DONE;
                end
            end
        end

        if (last_reg) begin
            expect_leader_next = 1'b1;
            leader_good_next   = 1'b0;
            count_mod4_next    = 2'd0;
            count_nz_next      = 1'b0;
            total_sat_next     = 2'd0;
            illegal_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_leader_reg <= 1'b1;
            leader_good_reg   <= 1'b0;
            count_mod4_reg    <= 2'd0;
            count_nz_reg      <= 1'b0;
            total_sat_reg     <= 2'd0;
            illegal_reg       <= 1'b0;
        end else if (advance) begin
            expect_leader_reg <= expect_leader_next;
            leader_good_reg   <= leader_good_next;
            count_mod4_reg    <= count_mod4_next;
            count_nz_reg      <= count_nz_next;
            total_sat_reg     <= total_sat_next;
            illegal_reg       <= illegal_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            bit_valid_reg <= bit_valid_next;
            bit_value_reg <= bit_value_next;
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = bit_valid_reg;
    assign m_tdata  = {4'b0, status_reg, bit_value_reg};

endmodule

[src/aeha_checker.sv]
// Port-level checker for the AEHA IR frame decoder, bound to the top level.
module aeha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser
);

    // a one bit is only ever shown with its valid flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> m_tuser)
        else $error("bit_value set without bit_valid");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] == aeha_pkg::ST_BUSY
                   || m_tdata[3:1] == aeha_pkg::ST_DONE
                   || m_tdata[3:1] == aeha_pkg::ST_SKIP
                   || m_tdata[3:1] == aeha_pkg::ST_ERROR
                   || m_tdata[3:1] == aeha_pkg::ST_NOT_AEHA))
        else $error("frame_status out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result word changed while stalled");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind aeha_ir_frame_decoder aeha_checker u_aeha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[verif/aeha_ir_frame_decoder_test.sv]
// Self-checking stream testbench for the AEHA IR frame decoder with APB timing setup.
`timescale 1ns / 100ps

module aeha_ir_frame_decoder_test;

    typedef struct packed {
        logic [14:0] hi;
        logic [14:0] lo;
        logic        last;
    } symbol_t;

    typedef struct packed {
        logic                    valid;
        logic                    value;
        aeha_pkg::frame_status_t status;
    } bit_result_t;

    typedef enum logic [1:0] {
        SYM_ZERO = 2'd0,
        SYM_ONE  = 2'd1,
        SYM_BAD  = 2'd2
    } sym_class_t;

    localparam int LEADER_HI_UNITS = 8;
    localparam int LEADER_LO_UNITS = 4;
    localparam int ONE_LO_UNITS    = 3;
    localparam int MAX_DUR         = 32767;
    localparam int PHASE_SYMBOLS   = 110;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    aeha_ir_frame_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    symbol_t     symbol_q[$];
    bit_result_t decoded_q[$];
    int          symbols_queued = 0;
    int          words_seen = 0;
    int          fail_count = 0;
    logic        calm = 1'b0;

    int          unit_cfg = int'(aeha_pkg::TIME_UNIT_RESET);
    int          tol_cfg = int'(aeha_pkg::TOLERANCE_RESET);

    logic        at_leader = 1'b1;
    logic        leader_ok = 1'b0;
    logic [1:0]  kept_mod4 = '0;
    logic        kept_any = 1'b0;
    logic [1:0]  seen_sat = '0;
    logic        broken = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < 34);
    endfunction

    function automatic bit near_units(logic [14:0] dur, int units);
        int nom;
        nom = units * unit_cfg;
        return (int'(dur) >= nom - tol_cfg) && (int'(dur) <= nom + tol_cfg);
    endfunction

    function automatic sym_class_t classify(logic [14:0] hi, logic [14:0] lo);
        if (!near_units(hi, 1))
            return SYM_BAD;
        if (near_units(lo, 1))
            return SYM_ZERO;
        if (near_units(lo, ONE_LO_UNITS))
            return SYM_ONE;
        return SYM_BAD;
    endfunction

    task automatic predict_symbol(input logic [14:0] hi, input logic [14:0] lo,
                                  input logic last, output bit_result_t res);
        sym_class_t code;
        res = '{valid: 1'b0, value: 1'b0, status: aeha_pkg::ST_BUSY};
        if (seen_sat != 2'd3)
            seen_sat = seen_sat + 2'd1;
        if (at_leader) begin
            at_leader = 1'b0;
            leader_ok = near_units(hi, LEADER_HI_UNITS) && near_units(lo, LEADER_LO_UNITS);
            if (last)
                res.status = (leader_ok || seen_sat <= 2'd2)
                           ? aeha_pkg::ST_SKIP : aeha_pkg::ST_NOT_AEHA;
        end else if (!leader_ok) begin
            if (last)
                res.status = (seen_sat > 2'd2) ? aeha_pkg::ST_NOT_AEHA : aeha_pkg::ST_SKIP;
        end else begin
            if (!(last && lo == 15'd0)) begin
                code = classify(hi, lo);
                kept_mod4 = kept_mod4 + 2'd1;
                kept_any = 1'b1;
                if (code == SYM_BAD) begin
                    broken = 1'b1;
                end else if (!broken) begin
                    res.valid = 1'b1;
                    res.value = (code == SYM_ONE);
                end
            end
            if (last) begin
                if (!kept_any || kept_mod4 != 2'd0)
                    res.status = aeha_pkg::ST_SKIP;
                else if (broken)
                    res.status = aeha_pkg::ST_ERROR;
                else
                    res.status = aeha_pkg::ST_DONE;
            end
        end
        if (last) begin
            at_leader = 1'b1;
            leader_ok = 1'b0;
            kept_mod4 = '0;
            kept_any = 1'b0;
            seen_sat = '0;
            broken = 1'b0;
        end
    endtask

    // Driver: feed queued symbols, predict each accepted word.
    always @(posedge aclk) begin
        bit_result_t res;
        symbol_t     sym;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_symbol(s_tdata[14:0], s_tdata[29:15], s_tlast, res);
                decoded_q.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (symbol_q.size() != 0 && !idle_roll()) begin
                    sym = symbol_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, sym.lo, sym.hi};
                    s_tlast <= sym.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction.
    always @(posedge aclk) begin
        bit_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("result word with no prediction pending");
                    fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tuser !== want.valid) begin
                        $error("bit_valid: expected %0d, got %0d", want.valid, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[0] !== want.value) begin
                        $error("bit_value: expected %0d, got %0d", want.value, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[3:1] !== want.status) begin
                        $error("frame_status: expected %0d, got %0d",
                               want.status, m_tdata[3:1]);
                        fail_count++;
                    end
                end
                words_seen <= words_seen + 1;
            end
            m_tready <= !idle_roll();
        end
    end

    task automatic push_sym(input int hi, input int lo, input logic last);
        symbol_q.push_back('{hi: hi[14:0], lo: lo[14:0], last: last});
        symbols_queued++;
    endtask

    function automatic int dur_near(int units);
        int nom;
        int off;
        int d;
        nom = units * unit_cfg;
        case ($urandom_range(9))
            0: off = -tol_cfg;
            1: off = tol_cfg;
            default: off = int'($urandom_range(2 * tol_cfg)) - tol_cfg;
        endcase
        d = nom + off;
        if (d < 0)
            d = 0;
        if (d > MAX_DUR)
            d = MAX_DUR;
        return d;
    endfunction

    function automatic int dur_miss(int units);
        int d;
        if ($urandom_range(1))
            d = units * unit_cfg + tol_cfg + 1 + int'($urandom_range(3));
        else
            d = units * unit_cfg - tol_cfg - 1 - int'($urandom_range(3));
        if (d < 0 || d > MAX_DUR)
            d = $urandom_range(MAX_DUR);
        return d;
    endfunction

    task automatic queue_bad_symbol(input logic last);
        case ($urandom_range(3))
            0: push_sym(dur_miss(1), dur_near(1), last);
            1: push_sym(dur_near(1), dur_miss(ONE_LO_UNITS), last);
            2: push_sym(dur_near(1), 0, last);
            default: push_sym($urandom_range(MAX_DUR), $urandom_range(MAX_DUR), last);
        endcase
    endtask

    task automatic queue_frame(input int n_data, input bit good_leader,
                               input bit end_drop, input bit add_bad);
        int   bad_pos;
        logic last;
        bad_pos = (n_data > 0) ? $urandom_range(n_data - 1) : -1;
        last = (n_data == 0) && !end_drop;
        if (good_leader)
            push_sym(dur_near(LEADER_HI_UNITS), dur_near(LEADER_LO_UNITS), last);
        else if ($urandom_range(1))
            push_sym(dur_miss(LEADER_HI_UNITS), dur_near(LEADER_LO_UNITS), last);
        else
            push_sym($urandom_range(MAX_DUR), $urandom_range(MAX_DUR), last);
        for (int i = 0; i < n_data; i++) begin
            last = (i == n_data - 1) && !end_drop;
            if (add_bad && i == bad_pos)
                queue_bad_symbol(last);
            else if ($urandom_range(1))
                push_sym(dur_near(1), dur_near(ONE_LO_UNITS), last);
            else
                push_sym(dur_near(1), dur_near(1), last);
        end
        if (end_drop)
            push_sym($urandom_range(1) ? dur_near(1) : $urandom_range(MAX_DUR), 0, 1'b1);
    endtask

    task automatic queue_random_mix(input int count);
        int start;
        int pick;
        int lens[6] = '{4, 8, 12, 16, 20, 32};
        start = symbols_queued;
        while (symbols_queued - start < count) begin
            pick = $urandom_range(99);
            if (pick < 60)
                queue_frame(lens[$urandom_range(5)], 1'b1, $urandom_range(3) == 0, 1'b0);
            else if (pick < 72)
                queue_frame($urandom_range(9), 1'b1, $urandom_range(1), 1'b0);
            else if (pick < 80)
                queue_frame(lens[$urandom_range(3)], 1'b1, $urandom_range(3) == 0, 1'b1);
            else if (pick < 88)
                queue_frame($urandom_range(5), 1'b0, $urandom_range(3) == 0, 1'b0);
            else
                repeat ($urandom_range(1, 6))
                    push_sym($urandom_range(MAX_DUR), $urandom_range(MAX_DUR),
                             $urandom_range(3) == 0);
        end
    endtask

    task automatic write_reg(input aeha_pkg::reg_index_t idx, input int value);
        logic [31:0] wdata;
        wdata = $urandom;
        if (idx == aeha_pkg::REG_TIME_UNIT)
            wdata[11:0] = value[11:0];
        else
            wdata[9:0] = value[9:0];
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == aeha_pkg::REG_TIME_UNIT)
            unit_cfg = value & 32'hFFF;
        else
            tol_cfg = value & 32'h3FF;
    endtask

    task automatic drain();
        wait (words_seen == symbols_queued);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int units[7] = '{560, 1, 4095, 100, 1, 300, 440};
        int tols[7]  = '{200, 0, 1023, 300, 1023, 0, 150};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        push_sym(3520, 1760, 1'b1);
        push_sym(0, 0, 1'b1);
        push_sym(32767, 32767, 1'b0);
        push_sym(440, 440, 1'b1);
        push_sym(0, 32767, 1'b0);
        push_sym(440, 440, 1'b0);
        push_sym(440, 1320, 1'b1);
        push_sym(3370, 1610, 1'b0);
        push_sym(290, 290, 1'b0);
        push_sym(590, 590, 1'b0);
        push_sym(440, 1170, 1'b0);
        push_sym(440, 1470, 1'b1);
        push_sym(3670, 1910, 1'b0);
        push_sym(440, 1320, 1'b0);
        push_sym(440, 440, 1'b0);
        push_sym(440, 1320, 1'b0);
        push_sym(440, 440, 1'b0);
        push_sym(440, 0, 1'b1);
        push_sym(3520, 1760, 1'b0);
        push_sym(440, 440, 1'b0);
        push_sym(440, 0, 1'b0);
        push_sym(289, 440, 1'b0);
        push_sym(440, 1320, 1'b1);
        push_sym(3520, 1760, 1'b0);
        push_sym(440, 440, 1'b0);
        push_sym(440, 1320, 1'b0);
        push_sym(440, 440, 1'b0);
        push_sym(440, 0, 1'b1);
        queue_random_mix(PHASE_SYMBOLS);
        drain();

        for (int p = 0; p < 7; p++) begin
            write_reg(aeha_pkg::REG_TIME_UNIT, units[p]);
            write_reg(aeha_pkg::REG_TOLERANCE, tols[p]);
            calm <= (p == 2);
            queue_random_mix(PHASE_SYMBOLS);
            drain();
        end

        if (decoded_q.size() != 0) begin
            $error("%0d predicted result words never arrived", decoded_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("aeha_ir_frame_decoder_test passed");
        else
            $display("aeha_ir_frame_decoder_test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("aeha_ir_frame_decoder_test failed");
        $finish;
    end

endmodule
